@@ design/hs_pkg.sv @@
// shared types and constants for the explicit heat stencil block
package hs_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned LAM_W = 16;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned CFG_W = 16;

  // request codes
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_ADVANCE = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;

  // configuration register indexes
  localparam logic REG_LAMBDA = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  localparam logic [LAM_W-1:0] LAMBDA_RST = 16'd16384;
  localparam logic [CNT_W-1:0] COUNT_RST  = 9'd256;
  localparam int unsigned      MIN_POINTS = 3;

  typedef logic signed [VAL_W-1:0] value_t;

  // three neighboring old-row values feeding one stencil evaluation
  typedef struct packed {
    value_t left;
    value_t centre;
    value_t right;
  } window_t;

endpackage

@@ design/hs_row_mem.sv @@
// row memory: one write port, one registered read port
module hs_row_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  hs_pkg::value_t   wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output hs_pkg::value_t   rdata
);

  hs_pkg::value_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/hs_stencil.sv @@
// two-stage stencil datapath: products, then sum, rounding and saturation
module hs_stencil #(
  parameter int unsigned AW = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [AW-1:0]             in_addr,
  input  hs_pkg::window_t           win,
  input  logic [hs_pkg::LAM_W-1:0]  lambda,
  output logic                      out_valid,
  output logic [AW-1:0]             out_addr,
  output hs_pkg::value_t            out_value
);

  logic signed [32:0] pair_sum;
  logic signed [16:0] lam_s;
  logic signed [17:0] ctr_w;
  logic signed [49:0] s1_p1;
  logic signed [49:0] s1_p2;
  logic               s1_valid;
  logic [AW-1:0]      s1_addr;
  logic signed [51:0] acc;
  logic signed [35:0] quot;
  hs_pkg::value_t     sat;

  assign pair_sum = 33'(win.left) + 33'(win.right);
  assign lam_s    = $signed({1'b0, lambda});
  // weight of the centre point: 1.0 - 2*lambda in signed q1.16
  assign ctr_w    = $signed(18'h10000 - {1'b0, lambda, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_addr <= in_addr;
    s1_p1   <= 50'(lam_s) * 50'(pair_sum);
    s1_p2   <= 50'(ctr_w) * 50'(win.centre);
  end

  // round half up, floor shift, clamp to 32 bits
  always_comb begin
    acc  = 52'(s1_p1) + 52'(s1_p2) + 52'sd32768;
    quot = acc[51:16];
    if (quot[35:31] == 5'b00000 || quot[35:31] == 5'b11111) begin
      sat = quot[31:0];
    end else if (quot[35]) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid;
    end
    out_addr  <= s1_addr;
    out_value <= sat;
  end

endmodule

@@ design/explicit_heat_stencil_step_top.sv @@
// explicit heat stencil step: top level with request sequencer and row memory
// load: written at the accepting edge, no result, next beat may follow at once
// read: busy while in the read state, done high in the cycle after it, value registered with done
// advance: busy through the sweep, drain and right-end states, one point per cycle through the memory
// reset clears control and config only; row entries stay undefined until loaded
// results cannot be stalled: done is high for exactly one cycle per read beat
module explicit_heat_stencil_step_top #(
  parameter int unsigned POINTS = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_addr,
  input  logic [hs_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                      start,
  input  logic [1:0]                req_type,
  input  logic [hs_pkg::IDX_W-1:0]  index,
  input  hs_pkg::value_t            sample,
  input  hs_pkg::value_t            left_boundary,
  input  hs_pkg::value_t            right_boundary,
  output logic                      busy,
  output logic                      done,
  output hs_pkg::value_t            point_value,
  output logic [hs_pkg::IDX_W-1:0]  point_index
);

  localparam int unsigned AW  = $clog2(POINTS);
  localparam int unsigned XW  = hs_pkg::IDX_W + AW;
  localparam int unsigned CW  = (AW + 1 > hs_pkg::CNT_W) ? AW + 1 : hs_pkg::CNT_W;
  localparam logic [XW-1:0] POINTS_X = XW'(POINTS);
  localparam logic [CW-1:0] POINTS_C = CW'(POINTS);
  localparam logic [CW-1:0] MIN_C    = CW'(hs_pkg::MIN_POINTS);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_RIGHT = 3'd4;

  // configuration registers
  logic [hs_pkg::LAM_W-1:0] lambda_coef;
  logic [hs_pkg::CNT_W-1:0] point_count;

  logic [2:0]      state;
  logic [2:0]      state_next;
  logic            accept;
  logic [XW-1:0]   idx_ext;
  logic [AW-1:0]   idx_addr;
  logic            idx_in_range;
  logic [CW-1:0]   cnt_ext;
  logic [CW-1:0]   n_use;
  logic [CW-1:0]   n_last;

  // advance bookkeeping
  logic [AW-1:0]   sweep_addr;
  logic [AW-1:0]   last_addr;
  hs_pkg::value_t  left_val;
  hs_pkg::value_t  right_val;
  logic            read_oob;

  // sweep read tag, lines up with memory read data
  logic            dvalid;
  logic [AW-1:0]   daddr;
  hs_pkg::value_t  win_l;
  hs_pkg::value_t  win_c;
  logic            st_launch;
  hs_pkg::window_t st_win;

  logic            st_out_valid;
  logic [AW-1:0]   st_out_addr;
  hs_pkg::value_t  st_out_value;
  logic            u_stencil_busy;

  // memory ports
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  hs_pkg::value_t  mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  hs_pkg::value_t  mem_rdata;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // index widened so the range check works for any row depth
  assign idx_ext      = {{AW{1'b0}}, index};
  assign idx_addr     = idx_ext[AW-1:0];
  assign idx_in_range = (idx_ext < POINTS_X);

  // clamp point count into [3, POINTS]
  always_comb begin
    cnt_ext = CW'(point_count);
    if (cnt_ext < MIN_C) begin
      n_use = MIN_C;
    end else if (cnt_ext > POINTS_C) begin
      n_use = POINTS_C;
    end else begin
      n_use = cnt_ext;
    end
    n_last = n_use - CW'(1);
  end

  // config write port
  always_ff @(posedge clk) begin
    if (rst) begin
      lambda_coef <= hs_pkg::LAMBDA_RST;
      point_count <= hs_pkg::COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        hs_pkg::REG_LAMBDA: lambda_coef <= cfg_wdata[hs_pkg::LAM_W-1:0];
        hs_pkg::REG_COUNT:  point_count <= cfg_wdata[hs_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && req_type == hs_pkg::REQ_READ) begin
          state_next = ST_READ;
        end else if (accept && req_type == hs_pkg::REQ_ADVANCE) begin
          state_next = ST_SWEEP;
        end
      end
      ST_READ:  state_next = ST_IDLE;
      ST_SWEEP: begin
        if (sweep_addr == last_addr) begin
          state_next = ST_DRAIN;
        end
      end
      // wait until the last read beat and the stencil pipe are empty
      ST_DRAIN: begin
        if (!dvalid && !st_launch && !st_out_valid && !u_stencil_busy) begin
          state_next = ST_RIGHT;
        end
      end
      ST_RIGHT: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      dvalid <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      dvalid <= (state == ST_SWEEP);
      done   <= (state == ST_READ);
    end
  end

  // advance setup and sweep address
  always_ff @(posedge clk) begin
    if (accept && req_type == hs_pkg::REQ_ADVANCE) begin
      sweep_addr <= '0;
      last_addr  <= n_last[AW-1:0];
      left_val   <= left_boundary;
      right_val  <= right_boundary;
    end else if (state == ST_SWEEP) begin
      sweep_addr <= sweep_addr + AW'(1);
    end
    daddr <= sweep_addr;
  end

  // sliding window of old-row values
  always_ff @(posedge clk) begin
    if (dvalid) begin
      win_l <= win_c;
      win_c <= mem_rdata;
    end
  end

  // once point i+1 arrives, point i has both neighbors
  assign st_launch     = dvalid && (daddr >= AW'(2));
  assign st_win.left   = win_l;
  assign st_win.centre = win_c;
  assign st_win.right  = mem_rdata;

  hs_stencil #(
    .AW (AW)
  ) u_stencil (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st_launch),
    .in_addr   (daddr - AW'(1)),
    .win       (st_win),
    .lambda    (lambda_coef),
    .out_valid (st_out_valid),
    .out_addr  (st_out_addr),
    .out_value (st_out_value)
  );

  // first stencil stage in flight, tracked here for the drain check
  always_ff @(posedge clk) begin
    if (rst) begin
      u_stencil_busy <= 1'b0;
    end else begin
      u_stencil_busy <= st_launch;
    end
  end

  // write port: load, left end, stencil results, right end never coincide
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_addr;
    mem_wdata = sample;
    if (accept && req_type == hs_pkg::REQ_LOAD && idx_in_range) begin
      mem_we = 1'b1;
    end else if (dvalid && daddr == '0) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = left_val;
    end else if (st_out_valid) begin
      mem_we    = 1'b1;
      mem_waddr = st_out_addr;
      mem_wdata = st_out_value;
    end else if (state == ST_RIGHT) begin
      mem_we    = 1'b1;
      mem_waddr = last_addr;
      mem_wdata = right_val;
    end
  end

  // read port: sweep reads run ahead of write-back, so old values are seen
  assign mem_re    = (state == ST_SWEEP) ||
                     (accept && req_type == hs_pkg::REQ_READ && idx_in_range);
  assign mem_raddr = (state == ST_SWEEP) ? sweep_addr : idx_addr;

  hs_row_mem #(
    .DEPTH (POINTS),
    .AW    (AW)
  ) u_row_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result beat registers
  always_ff @(posedge clk) begin
    if (accept && req_type == hs_pkg::REQ_READ) begin
      point_index <= index;
      read_oob    <= !idx_in_range;
    end
    if (state == ST_READ) begin
      point_value <= read_oob ? '0 : mem_rdata;
    end
  end

  // a result beat only follows the read state
  a_done_after_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_READ)
    else $error("result beat without a read");

  // stencil write-back only happens during an advance
  a_stencil_in_advance: assert property (@(posedge clk) disable iff (rst)
    st_out_valid |-> (state == ST_SWEEP || state == ST_DRAIN))
    else $error("stencil result outside an advance");

  // an idle write is always a load
  a_idle_write_is_load: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == ST_IDLE) |-> (start && req_type == hs_pkg::REQ_LOAD))
    else $error("unexpected row write while idle");

  // the right end is written last, then the block is free
  a_right_then_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RIGHT) |=> (state == ST_IDLE && !st_out_valid))
    else $error("advance did not finish after right end write");

endmodule
